// ===== rtl/lvq_pkg.sv =====
// shared field widths and constants for the linear value quantizer
package lvq_pkg;

  localparam int IDX_W  = 8;   // variable index width
  localparam int NB_W   = 5;   // bit count field width
  localparam int WORD_W = 32;  // Q16.16 word width
  localparam int IN_W   = 112; // packed input tdata width, byte aligned

endpackage

// ===== rtl/linear_value_quantizer_unit.sv =====
// linear value quantizer: clamp, pipelined rounding divide, pipelined reconstruction
//
//   port group | dir | payload (lowest bits first)
//   -----------+-----+---------------------------------------------------------
//   in_*       | in  | variable_index, num_bits, value, range_min, range_max
//   out_*      | out | tdata: index_out, code_word, decoded_value; tuser: skipped
//
// one transfer in per cycle while the output is not stalled, one result per item; the
// stages are input and prepare, one multiply, the rounding numerator, one stage per
// code bit in the code divider, one multiply, one stage per quotient bit in the
// 32-bit reconstruction divider, and the output register. rst_n synchronously clears
// all stage valid bits. a stalled output freezes every stage together; nothing is
// dropped or repeated.
module linear_value_quantizer_unit #(
  parameter int MAX_BITS = 24,
  localparam int OUT_W = ((lvq_pkg::IDX_W + MAX_BITS + lvq_pkg::WORD_W + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // variable_index, num_bits, value, range_min, range_max, zero fill
  input  logic [lvq_pkg::IN_W-1:0] in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // index_out, code_word, decoded_value, zero fill
  output logic [OUT_W-1:0]         out_tdata,
  // skipped
  output logic                     out_tuser
);

  localparam int MB  = MAX_BITS;
  localparam int WW  = lvq_pkg::WORD_W;
  localparam int NW1 = WW + MB + 2;   // rounding numerator width
  localparam int PW  = WW + MB;       // reconstruction product width

  typedef struct packed {
    logic [lvq_pkg::IDX_W-1:0] idx;
    logic                      skip;
    logic                      eq;
    logic                      lt;
    logic [MB-1:0]             m;
    logic [WW-1:0]             span;
    logic [WW-1:0]             lo;
    logic [WW-1:0]             hi;
  } ctx_t;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // input unpack and prepare
  logic [lvq_pkg::IDX_W-1:0] f_idx;
  logic [lvq_pkg::NB_W-1:0]  f_nb, n_eff;
  logic signed [WW-1:0]      f_val, f_lo, f_hi, b_lo, b_cl;
  logic [MB:0]               m_full;
  ctx_t                      ctx_nxt;

  assign f_idx = in_tdata[7:0];
  assign f_nb  = in_tdata[12:8];
  assign f_val = in_tdata[44:13];
  assign f_lo  = in_tdata[76:45];
  assign f_hi  = in_tdata[108:77];

  always_comb begin
    n_eff  = (f_nb > lvq_pkg::NB_W'(MB)) ? lvq_pkg::NB_W'(MB) : f_nb;
    m_full = ((MB+1)'(1) << n_eff) - (MB+1)'(1);
    b_lo   = (f_val < f_lo) ? f_lo : f_val;
    b_cl   = (b_lo > f_hi) ? f_hi : b_lo;
    ctx_nxt.idx  = f_idx;
    ctx_nxt.skip = (f_nb == '0);
    ctx_nxt.eq   = (f_hi == f_lo);
    ctx_nxt.lt   = (f_hi < f_lo);
    ctx_nxt.m    = m_full[MB-1:0];
    ctx_nxt.span = WW'(f_hi - f_lo);
    ctx_nxt.lo   = f_lo;
    ctx_nxt.hi   = f_hi;
  end

  logic          v0_r, v1_r;
  ctx_t          ctx0_r, ctx1_r;
  logic [WW-1:0] off0_r;
  logic [PW-1:0] prod1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx0_r  <= ctx_nxt;
      off0_r  <= WW'(b_cl - f_lo);
      ctx1_r  <= ctx0_r;
      prod1_r <= PW'(off0_r) * PW'(ctx0_r.m);
    end
  end

  // code divider: num = 2*off*m + span over den = 2*span, one quotient bit a stage
  logic           d1_v_r   [0:MB];
  ctx_t           d1_ctx_r [0:MB];
  logic [NW1-1:0] d1_rem_r [0:MB];
  logic [MB-1:0]  d1_q_r   [0:MB];

  always_ff @(posedge clk) begin
    if (!rst_n) d1_v_r[0] <= 1'b0;
    else if (en) d1_v_r[0] <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_ctx_r[0] <= ctx1_r;
      d1_rem_r[0] <= {prod1_r, 1'b0} + NW1'(ctx1_r.span);
      d1_q_r[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= MB; k++) begin : g_div1
    localparam int BI = MB - k;
    logic [NW1-1:0] dsh;
    logic           ge;
    logic [MB-1:0]  q_nxt;
    always_comb begin
      dsh       = NW1'({d1_ctx_r[k-1].span, 1'b0}) << BI;
      ge        = d1_rem_r[k-1] >= dsh;
      q_nxt     = d1_q_r[k-1];
      q_nxt[BI] = ge;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) d1_v_r[k] <= 1'b0;
      else if (en) d1_v_r[k] <= d1_v_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d1_ctx_r[k] <= d1_ctx_r[k-1];
        d1_rem_r[k] <= ge ? d1_rem_r[k-1] - dsh : d1_rem_r[k-1];
        d1_q_r[k]   <= q_nxt;
      end
    end
  end

  // saturate the code and form code*span
  logic [MB-1:0] code_sat;
  assign code_sat = (d1_q_r[MB] > d1_ctx_r[MB].m) ? d1_ctx_r[MB].m : d1_q_r[MB];

  // reconstruction divider: code*span over m, 32 quotient bits
  logic          d2_v_r    [0:WW];
  ctx_t          d2_ctx_r  [0:WW];
  logic [MB-1:0] d2_code_r [0:WW];
  logic [PW-1:0] d2_rem_r  [0:WW];
  logic [WW-1:0] d2_q_r    [0:WW];

  always_ff @(posedge clk) begin
    if (!rst_n) d2_v_r[0] <= 1'b0;
    else if (en) d2_v_r[0] <= d1_v_r[MB];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_ctx_r[0]  <= d1_ctx_r[MB];
      d2_code_r[0] <= code_sat;
      d2_rem_r[0]  <= PW'(code_sat) * PW'(d1_ctx_r[MB].span);
      d2_q_r[0]    <= '0;
    end
  end

  for (genvar k = 1; k <= WW; k++) begin : g_div2
    localparam int BI = WW - k;
    logic [PW-1:0] msh;
    logic          ge;
    logic [WW-1:0] q_nxt;
    always_comb begin
      msh       = PW'(d2_ctx_r[k-1].m) << BI;
      ge        = d2_rem_r[k-1] >= msh;
      q_nxt     = d2_q_r[k-1];
      q_nxt[BI] = ge;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) d2_v_r[k] <= 1'b0;
      else if (en) d2_v_r[k] <= d2_v_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d2_ctx_r[k]  <= d2_ctx_r[k-1];
        d2_code_r[k] <= d2_code_r[k-1];
        d2_rem_r[k]  <= ge ? d2_rem_r[k-1] - msh : d2_rem_r[k-1];
        d2_q_r[k]    <= q_nxt;
      end
    end
  end

  // result select and output register
  ctx_t          fc;
  logic [MB-1:0] code_nxt;
  logic [WW-1:0] dec_nxt;
  logic          out_valid_r, out_skip_r;
  logic [OUT_W-1:0] out_data_r;

  always_comb begin
    fc = d2_ctx_r[WW];
    if (fc.skip) begin
      code_nxt = '0;
      dec_nxt  = '0;
    end else if (fc.eq) begin
      code_nxt = '0;
      dec_nxt  = fc.lo;
    end else if (fc.lt) begin
      code_nxt = fc.m;
      dec_nxt  = fc.hi;
    end else begin
      code_nxt = d2_code_r[WW];
      dec_nxt  = fc.lo + d2_q_r[WW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= d2_v_r[WW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= OUT_W'({dec_nxt, code_nxt, fc.idx});
      out_skip_r <= fc.skip;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_skip_r;

  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[OUT_W-1:lvq_pkg::IDX_W] == '0)
    else $error("skipped result carries nonzero code or value");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v0_r) && $stable(v1_r) && $stable(d1_v_r[0]))
    else $error("pipeline moved during stall");

  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> v0_r == $past(in_tvalid))
    else $error("accepted transfer not captured");

endmodule

// ===== dv/tb_linear_value_quantizer_unit.sv =====
// self-checking testbench for the linear value quantizer unit
`timescale 1ns / 100ps

module tb_linear_value_quantizer_unit;

  localparam int MAXB    = 24;
  localparam int OUT_W   = ((lvq_pkg::IDX_W + MAXB + lvq_pkg::WORD_W + 7) / 8) * 8;
  localparam int LATENCY = MAXB + 37;

  typedef struct packed {
    logic [lvq_pkg::IDX_W-1:0]  idx;
    logic [23:0]                code;
    logic [lvq_pkg::WORD_W-1:0] dec;
    logic                       skip;
  } quant_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [lvq_pkg::IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic out_tuser;

  quant_res_t quant_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  bit hold_off = 1'b0;
  bit no_stall = 1'b0;

  always #5 clk = ~clk;

  linear_value_quantizer_unit #(.MAX_BITS(MAXB)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  // predict the code and the reconstruction for one item
  function automatic quant_res_t quantize(logic [7:0] idx, logic [4:0] nb,
                                          logic signed [31:0] val,
                                          logic signed [31:0] lo,
                                          logic signed [31:0] hi);
    quant_res_t r;
    int n;
    logic [63:0] mc, span, off, num, q;
    logic signed [63:0] b, l, h, d;
    r = '0;
    r.idx = idx;
    if (nb == 0) begin
      r.skip = 1'b1;
      return r;
    end
    n = (nb > MAXB) ? MAXB : nb;
    mc = (64'd1 << n) - 64'd1;
    l = lo;
    h = hi;
    b = val;
    if (b < l) b = l;
    if (b > h) b = h;
    if (h == l) begin
      q = 0;
      d = l;
    end else if (h < l) begin
      q = mc;
      d = h;
    end else begin
      span = h - l;
      off = b - l;
      num = 2 * off * mc + span;
      q = num / (2 * span);
      if (q > mc) q = mc;
      d = l + signed'((q * span) / mc);
    end
    r.code = q[23:0];
    r.dec = d[31:0];
    return r;
  endfunction

  task automatic send_item(logic [7:0] idx, logic [4:0] nb, logic [31:0] val,
                           logic [31:0] lo, logic [31:0] hi);
    in_tdata <= {{(lvq_pkg::IN_W - 109){1'b0}}, hi, lo, val, nb, idx};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    quant_q.push_back(quantize(idx, nb, val, lo, hi));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic idle_sender();
    in_tvalid <= 1'b0;
  endtask

  task automatic drain();
    idle_sender();
    while (quant_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 255) - 128;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_item(8'h00, 5'd0, 32'h0001_0000, 32'h0, 32'h0002_0000);  // skip
    send_item(8'hff, 5'd31, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_item(8'h01, 5'd24, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_item(8'h02, 5'd1, 32'h0, 32'hffff_0000, 32'h0001_0000);
    send_item(8'h03, 5'd8, 32'h0005_0000, 32'h0003_0000, 32'h0003_0000); // equal bounds
    send_item(8'h04, 5'd8, 32'h0005_0000, 32'h0004_0000, 32'h0001_0000); // max below min
    send_item(8'h05, 5'd4, 32'h8000_0000, 32'h0, 32'h0001_0000);  // below range
    send_item(8'h06, 5'd4, 32'h7fff_ffff, 32'h0, 32'h0001_0000);  // above range
    send_item(8'h07, 5'd2, 32'h0000_8000, 32'h0, 32'h0001_0000);  // exact half
    send_item(8'h08, 5'd1, 32'd1, 32'd0, 32'd2);                  // half rounds up
    send_item(8'h09, 5'd25, 32'h1234_5678, 32'hf000_0000, 32'h2000_0000);
    send_item(8'haa, 5'd16, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
    send_item(8'h55, 5'd3, 32'h0, 32'hffff_ffff, 32'h1);
    drain();
  endtask

  task automatic test_random(int count);
    int burst;
    logic [31:0] a, c;
    for (int i = 0; i < count; i++) begin
      a = rand_word();
      c = rand_word();
      // mostly ordered ranges, some reversed or equal
      if ($urandom_range(0, 9) < 8 && signed'(a) > signed'(c)) {a, c} = {c, a};
      if ($urandom_range(0, 30) == 0) c = a;
      send_item(8'($urandom),
                5'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 24)),
                $urandom_range(0, 3) == 0 ? rand_word() :
                  a + (c - a) / 2 + $urandom_range(0, 9999) - 5000,
                a, c);
      burst = $urandom_range(0, 3);
      if (burst == 0) begin
        idle_sender();
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 150; i++)
      send_item(i[7:0], 5'($urandom_range(1, 24)), $urandom, 32'hc000_0000, 32'h4000_0000);
    drain();
    // full rate with no receiver stalls
    no_stall = 1'b1;
    for (int i = 0; i < 200; i++)
      send_item(8'($urandom), 5'($urandom_range(0, 24)), $urandom,
                32'hff00_0000, 32'h0100_0000);
    drain();
    no_stall = 1'b0;
  endtask

  // receiver stall pattern, with one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off) begin
      out_tready <= 1'b0;
      repeat (300) @(negedge clk);
      hold_off = 1'b0;
    end else begin
      out_tready <= no_stall || ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    quant_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.idx = out_tdata[7:0];
      got.code = out_tdata[31:8];
      got.dec = out_tdata[63:32];
      got.skip = out_tuser;
      n_recv++;
      if (quant_q.size() == 0) begin
        $display("%0t: result with none expected: %p", $time, got);
        errors++;
      end else begin
        want = quant_q.pop_front();
        if (got.idx !== want.idx) begin
          $display("%0t: index expected %0d actual %0d", $time, want.idx, got.idx);
          errors++;
        end
        if (got.code !== want.code) begin
          $display("%0t: code expected %h actual %h", $time, want.code, got.code);
          errors++;
        end
        if (got.dec !== want.dec) begin
          $display("%0t: decoded expected %h actual %h", $time, want.dec, got.dec);
          errors++;
        end
        if (got.skip !== want.skip) begin
          $display("%0t: skipped expected %b actual %b", $time, want.skip, got.skip);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_random(1450);
    repeat (2 * LATENCY) @(negedge clk);
    if (quant_q.size() != 0) begin
      $display("%0d expected results never arrived", quant_q.size());
      errors++;
    end
    $display("covered %0d items, %0d results: bounds, skips, reversed and equal ranges,",
             n_sent, n_recv);
    $display("random bursts, receiver stalls and a long output hold-off");
    if (errors == 0) begin
      $display("tb_linear_value_quantizer_unit OK");
    end else begin
      $display("tb_linear_value_quantizer_unit NOT OK");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("tb_linear_value_quantizer_unit NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lvq_pkg.sv
rtl/linear_value_quantizer_unit.sv
dv/tb_linear_value_quantizer_unit.sv
